FILE: rtl/core/etp_pkg.sv
// Shared types and constants for the equal tower partition block.
`default_nettype none

package etp_pkg;

   // Default table size: the largest height difference that is kept.
   localparam int MAX_SUM_DEF = 2048;

   // Fixed field widths.
   localparam int HEIGHT_W = 12;
   localparam int TOWER_W  = 11;
   localparam int ENTRY_H_W = 13;
   localparam int ENTRY_W   = ENTRY_H_W + 1;

   // Saturation limits for stored heights and for the reported height.
   localparam logic [ENTRY_H_W-1:0] HEIGHT_CAP = 13'd8191;
   localparam logic [ENTRY_H_W-1:0] OUT_CAP    = 13'd2047;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // The three candidates offered for one table entry.
   typedef enum logic [1:0] {
      PH_KEEP,
      PH_CROSS,
      PH_SHORT
   } phase_type;

endpackage

`default_nettype wire

FILE: rtl/core/equal_tower_partition_dp.sv
// Top level of the equal tower partition block: sequencer, table banks and max unit.
//
//   channel | dir | handshake            | contents
//   req     | in  | req_tvalid/tready    | tdata: height; tlast: last block of the set
//   rsp     | out | rsp_tvalid/tready    | tdata: tower_height, possible, overflow
//
// For each block, every table entry needs three reads of the previous bank through
// its single read port, and one shared saturating add and max unit folds the three
// candidates.
// Reset is synchronous and active high; it marks the table as freshly cleared, so no
// clearing pass is needed, and the same happens after each last block.
// req_tready is high only while the sequencer is idle. A finished result waits in an
// output register while the next block is taken; a later result stalls until it drains.
`default_nettype none

module equal_tower_partition_dp
   import etp_pkg::*;
#(
   parameter int MAX_SUM = MAX_SUM_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [11:0] height, [15:12] zero
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // [10:0] tower_height, [11] possible,
                                         // [12] overflow, [15:13] zero
);

   // Derived widths.
   localparam int IW = $clog2(MAX_SUM + 1);
   localparam int CW = ((IW > HEIGHT_W) ? IW : HEIGHT_W) + 1;
   localparam int RW = $clog2(MAX_SUM + 2);
   localparam int SW = ((RW > HEIGHT_W) ? RW : HEIGHT_W) + 1;
   localparam logic [IW-1:0] J_MAX = IW'(MAX_SUM);

   // One read in flight toward the max unit.
   typedef struct packed {
      logic                vld;
      phase_type           ph;
      logic [IW-1:0]       j;
      logic                present;
      logic                zero_addr;
      logic [HEIGHT_W-1:0] add;
   } stage_type;

   state_type           state_ff, state_in;
   phase_type           p_ff, p_in;
   logic [IW-1:0]       j_ff, j_in;
   logic [HEIGHT_W-1:0] h_ff;
   logic                last_ff;
   logic                bank_ff;
   logic                fresh_ff;
   logic [RW-1:0]       rsum_ff;
   logic                ovf_ff;
   stage_type           s1_ff, s1_in;
   logic                acc_have_ff, acc_have_in;
   logic [ENTRY_H_W-1:0] acc_best_ff, acc_best_in;
   logic [ENTRY_W-1:0]  res_ff;
   logic                rsp_valid_ff;
   logic [TOWER_W-1:0]  rsp_tower_ff;
   logic                rsp_poss_ff;
   logic                rsp_ovf_ff;

   logic                accept;
   logic                issue;
   logic                rsp_load;
   logic [IW-1:0]       raddr;
   logic                wr_en;
   logic [ENTRY_W-1:0]  wdata;

   // Table banks.
   logic [ENTRY_W-1:0]  mem_even_ff [MAX_SUM+1];
   logic [ENTRY_W-1:0]  mem_odd_ff  [MAX_SUM+1];
   logic [ENTRY_W-1:0]  rd_even_ff;
   logic [ENTRY_W-1:0]  rd_odd_ff;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // Sequencer: next state, index and phase counters.
   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      p_in     = p_ff;
      issue    = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SWEEP;
               j_in     = '0;
               p_in     = PH_KEEP;
            end
         end
         ST_SWEEP: begin
            issue = 1'b1;
            case (p_ff)
               PH_KEEP:  p_in = PH_CROSS;
               PH_CROSS: p_in = PH_SHORT;
               default: begin
                  p_in = PH_KEEP;
                  if (j_ff == J_MAX) begin
                     state_in = ST_DRAIN;
                  end else begin
                     j_in = j_ff + IW'(1);
                  end
               end
            endcase
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         j_ff     <= '0;
         p_ff     <= PH_KEEP;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         p_ff     <= p_in;
      end
   end

   // Candidate address for the current phase of entry j.
   logic [CW-1:0] j_ext, h_ext, diff_jh, diff_hj, sum_jh, max_ext;
   always_comb begin
      j_ext   = CW'(j_ff);
      h_ext   = CW'(h_ff);
      diff_jh = j_ext - h_ext;
      diff_hj = h_ext - j_ext;
      sum_jh  = j_ext + h_ext;
      max_ext = CW'(MAX_SUM);
      s1_in       = '0;
      s1_in.vld   = issue;
      s1_in.ph    = p_ff;
      s1_in.j     = j_ff;
      raddr       = j_ff;
      case (p_ff)
         PH_KEEP: begin
            s1_in.present = 1'b1;
         end
         PH_CROSS: begin
            if (j_ext >= h_ext) begin
               s1_in.present = 1'b1;
               raddr         = diff_jh[IW-1:0];
               s1_in.add     = h_ff;
            end else if (diff_hj <= max_ext) begin
               s1_in.present = 1'b1;
               raddr         = diff_hj[IW-1:0];
               s1_in.add     = j_ext[HEIGHT_W-1:0];
            end
         end
         default: begin
            if (sum_jh <= max_ext) begin
               s1_in.present = 1'b1;
               raddr         = sum_jh[IW-1:0];
            end
         end
      endcase
      s1_in.zero_addr = (raddr == '0);
   end

   // Shared saturating add and max unit folds one candidate per cycle.
   logic [ENTRY_W-1:0]   entry;
   logic                 cand_ok;
   logic [ENTRY_H_W:0]   cand_sum;
   logic [ENTRY_H_W-1:0] cand;
   logic                 base_have;
   logic [ENTRY_H_W-1:0] base_best;
   always_comb begin
      if (fresh_ff) begin
         entry = s1_ff.zero_addr ? {1'b1, {ENTRY_H_W{1'b0}}} : '0;
      end else if (bank_ff) begin
         entry = rd_odd_ff;
      end else begin
         entry = rd_even_ff;
      end
      cand_ok  = s1_ff.present && entry[ENTRY_W-1];
      cand_sum = (ENTRY_H_W+1)'(entry[ENTRY_H_W-1:0]) + (ENTRY_H_W+1)'(s1_ff.add);
      cand     = (cand_sum > (ENTRY_H_W+1)'(HEIGHT_CAP)) ? HEIGHT_CAP
                                                         : cand_sum[ENTRY_H_W-1:0];
      base_have = (s1_ff.ph == PH_KEEP) ? 1'b0 : acc_have_ff;
      base_best = acc_best_ff;
      acc_have_in = base_have || cand_ok;
      if (cand_ok && (!base_have || cand > base_best)) begin
         acc_best_in = cand;
      end else begin
         acc_best_in = base_have ? base_best : '0;
      end
      wr_en = s1_ff.vld && (s1_ff.ph == PH_SHORT);
      wdata = acc_have_in ? {1'b1, acc_best_in} : '0;
   end

   // Table banks: read the previous bank, write the next one.
   always_ff @(posedge clock) begin
      if (wr_en && bank_ff) begin
         mem_even_ff[s1_ff.j] <= wdata;
      end
      rd_even_ff <= mem_even_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (wr_en && !bank_ff) begin
         mem_odd_ff[s1_ff.j] <= wdata;
      end
      rd_odd_ff <= mem_odd_ff[raddr];
   end

   // Pipeline stage, accumulator and the captured entry zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld <= 1'b0;
      end else begin
         s1_ff.vld <= s1_in.vld;
      end
      s1_ff.ph        <= s1_in.ph;
      s1_ff.j         <= s1_in.j;
      s1_ff.present   <= s1_in.present;
      s1_ff.zero_addr <= s1_in.zero_addr;
      s1_ff.add       <= s1_in.add;
      if (s1_ff.vld) begin
         acc_have_ff <= acc_have_in;
         acc_best_ff <= acc_best_in;
      end
      if (wr_en && s1_ff.j == '0) begin
         res_ff <= wdata;
      end
   end

   // Set state: accepted word, running sum, bank select and fresh mark.
   logic [SW-1:0] rsum_next;
   assign rsum_next = SW'(rsum_ff) + SW'(req_tdata[HEIGHT_W-1:0]);

   always_ff @(posedge clock) begin
      if (accept) begin
         h_ff    <= req_tdata[HEIGHT_W-1:0];
         last_ff <= req_tlast;
      end
      if (reset) begin
         bank_ff  <= 1'b0;
         fresh_ff <= 1'b1;
         rsum_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else if (rsp_load) begin
         bank_ff  <= 1'b0;
         fresh_ff <= 1'b1;
         rsum_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         if (accept) begin
            if (rsum_next > SW'(MAX_SUM)) begin
               rsum_ff <= RW'(MAX_SUM + 1);
               ovf_ff  <= 1'b1;
            end else begin
               rsum_ff <= rsum_next[RW-1:0];
            end
         end
         if (state_ff == ST_DONE && state_in == ST_IDLE) begin
            bank_ff  <= ~bank_ff;
            fresh_ff <= 1'b0;
         end
      end
   end

   // Output register.
   logic [ENTRY_H_W-1:0] res_h;
   assign res_h = res_ff[ENTRY_W-1] ? res_ff[ENTRY_H_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_tower_ff <= (res_h > OUT_CAP) ? OUT_CAP[TOWER_W-1:0] : res_h[TOWER_W-1:0];
         rsp_poss_ff  <= (res_h != '0);
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ovf_ff, rsp_poss_ff, rsp_tower_ff};

`ifndef ASSERT_OFF
   // A read in flight only exists while the sweep runs or drains.
   a_stage_in_sweep: assert property (@(posedge clock) disable iff (reset)
      s1_ff.vld |-> (state_ff == ST_SWEEP || state_ff == ST_DRAIN))
      else $error("read in flight outside the sweep");

   // The drain starts only after the last entry's closing phase was issued.
   a_sweep_complete: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_DRAIN) |-> ($past(j_ff) == J_MAX && $past(p_ff) == PH_SHORT))
      else $error("sweep ended before the last table entry");

   // The running sum never passes its saturation value.
   a_rsum_bound: assert property (@(posedge clock) disable iff (reset)
      rsum_ff <= RW'(MAX_SUM + 1))
      else $error("running sum beyond saturation");

   // A reported height is nonzero exactly when a split is possible.
   a_possible_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_tower_ff != '0) == rsp_poss_ff))
      else $error("possible flag disagrees with tower height");

   // Delivering a result leaves the set state cleared.
   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (fresh_ff && rsum_ff == '0 && !ovf_ff && !bank_ff))
      else $error("set state not cleared after last word");
`endif

endmodule

`default_nettype wire

FILE: sim/equal_tower_partition_dp_tb.sv
// Self-checking testbench for the equal tower partition block, with a scoreboard class.
module equal_tower_partition_dp_tb;
   import etp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_MAX   = MAX_SUM_DEF;
   // Budget for one block: three candidate reads for every table entry plus the sequencer overhead.
   localparam int BLOCK_CYCLES = 3 * (TABLE_MAX + 1) + 3;
   localparam int TAIL_CYCLES  = BLOCK_CYCLES + 64;
   localparam int RANDOM_ITEMS = 76;
   localparam int MAX_REPORTS  = 10;

   // One expected answer word, split into its fields.
   typedef struct {
      logic [TOWER_W-1:0] tower_height;
      logic               possible;
      logic               overflow;
   } answer_type;

   // Predicts the answer of each set of blocks and checks the answer words in order.
   class partition_tracker;
      bit [ENTRY_W-1:0] banks [2][TABLE_MAX+1];
      int               bank_sel;
      int               set_sum;
      bit               set_overflow;
      answer_type       answers_due[$];
      int               errors;

      function new();
         errors = 0;
         clear_set();
      endfunction

      // Back to the freshly cleared table: only difference zero is reachable.
      function void clear_set();
         foreach (banks[b, j]) banks[b][j] = '0;
         banks[0][0] = {1'b1, {ENTRY_H_W{1'b0}}};
         bank_sel = 0;
         set_sum = 0;
         set_overflow = 1'b0;
      endfunction

      // Height that one table entry offers with a block added, or -1 if unreachable.
      function int fold_candidate(bit [ENTRY_W-1:0] entry, int add);
         int v;
         if (!entry[ENTRY_W-1]) return -1;
         v = int'(entry[ENTRY_H_W-1:0]) + add;
         if (v > int'(HEIGHT_CAP)) v = int'(HEIGHT_CAP);
         return v;
      endfunction

      // Rebuild the table for one accepted block; a last block queues an answer.
      function void absorb_block(logic [HEIGHT_W-1:0] height, bit last);
         int               h;
         int               src;
         int               dst;
         int               best;
         int               c;
         int               height_out;
         bit [ENTRY_W-1:0] top;
         answer_type       ans;
         h = int'(height);
         src = bank_sel;
         dst = 1 - bank_sel;
         set_sum += h;
         if (set_sum > TABLE_MAX) begin
            set_sum = TABLE_MAX + 1;
            set_overflow = 1'b1;
         end
         // Leave the block out, stack it on the taller tower, or on the shorter one.
         for (int j = 0; j <= TABLE_MAX; j++) begin
            best = fold_candidate(banks[src][j], 0);
            if (j >= h) begin
               c = fold_candidate(banks[src][j-h], h);
            end else if (h - j <= TABLE_MAX) begin
               c = fold_candidate(banks[src][h-j], j);
            end else begin
               c = -1;
            end
            if (c > best) best = c;
            if (j + h <= TABLE_MAX) begin
               c = fold_candidate(banks[src][j+h], 0);
               if (c > best) best = c;
            end
            banks[dst][j] = (best < 0) ? '0 : {1'b1, best[ENTRY_H_W-1:0]};
         end
         bank_sel = dst;
         if (!last) return;
         // Difference zero holds the equal tower height; the port saturates it.
         top = banks[bank_sel][0];
         height_out = top[ENTRY_W-1] ? int'(top[ENTRY_H_W-1:0]) : 0;
         if (height_out > int'(OUT_CAP)) height_out = int'(OUT_CAP);
         ans.tower_height = height_out[TOWER_W-1:0];
         ans.possible = (height_out > 0);
         ans.overflow = set_overflow;
         answers_due.push_back(ans);
         clear_set();
      endfunction

      // Compare one accepted answer word with the oldest expected answer.
      function void check_answer(logic [15:0] word);
         answer_type want;
         if (answers_due.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected answer word %h", $realtime, word);
            return;
         end
         want = answers_due.pop_front();
         if (word[10:0] !== want.tower_height || word[11] !== want.possible ||
             word[12] !== want.overflow) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: mismatch: expected h %0d p %0d o %0d, got h %0d p %0d o %0d",
                        $realtime, want.tower_height, want.possible, want.overflow,
                        word[10:0], word[11], word[12]);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [11:0] height, [15:12] zero
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [10:0] tower_height, [11] possible, [12] overflow

   partition_tracker tracker = new();
   int burst_left = 0;

   equal_tower_partition_dp dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Free-running clock, 4 ns period.
   initial begin
      forever #2 clock = ~clock;
   end

   // Run guard.
   initial begin
      #40_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Check every answer word taken at a rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_answer(rsp_tdata);
   end

   // Receiver: ready stretches, bit patterns, and a rare long stall.
   initial begin : answer_backpressure
      int          mode;
      int          span;
      logic [31:0] pattern;
      forever begin
         mode = $urandom_range(0, 199);
         if (mode == 0) begin
            span = $urandom_range(500, 8000);
            repeat (span) @(negedge clock) rsp_tready <= 1'b0;
         end else if (mode < 70) begin
            span = $urandom_range(16, 256);
            repeat (span) @(negedge clock) rsp_tready <= 1'b1;
         end else begin
            pattern = $urandom;
            for (int i = 0; i < 32; i++) @(negedge clock) rsp_tready <= pattern[i];
         end
      end
   end

   // Offer one block word; between bursts the sender idles for a random gap.
   task automatic push_block(input logic [HEIGHT_W-1:0] height, input bit last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 4);
         if ($urandom_range(0, 2) == 0) gap = 0;
         else if ($urandom_range(0, 12) == 0) gap = $urandom_range(100, 6500);
         else gap = $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock) req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, height};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      tracker.absorb_block(height, last);
      burst_left--;
   endtask

   // Hold off the sender until every expected answer has come back.
   task automatic drain_answers();
      @(negedge clock) req_tvalid <= 1'b0;
      burst_left = 0;
      while (tracker.answers_due.size() != 0) @(posedge clock);
   endtask

   // Block height for random sets: mostly small, sometimes past the table size.
   function automatic logic [HEIGHT_W-1:0] pick_height();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return HEIGHT_W'($urandom_range(1, 30));
      if (r < 85) return HEIGHT_W'($urandom_range(0, 300));
      if (r < 95) return HEIGHT_W'($urandom_range(0, TABLE_MAX));
      return HEIGHT_W'($urandom_range(0, 4095));
   endfunction

   // Reset, directed sets, random sets, then wait for the last answers.
   initial begin
      int dir_h [24];
      bit dir_l [24];
      int sent;
      int set_len;
      dir_h = '{0, 4095, 5, 5, 1, 2, 3, 1000, 1001, 2048, 2048, 2049, 1,
                3, 4095, 3, 2048, 2048, 2048, 2048, 2048, 2048, 2048, 2048};
      dir_l = '{1, 1, 0, 1, 0, 0, 1, 0, 1, 0, 1, 0, 1,
                0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1};
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed: zero height, all-ones height, simple pairs, an impossible split,
      // output saturation, heights past the table, and stored height saturation.
      foreach (dir_h[i]) push_block(HEIGHT_W'(dir_h[i]), dir_l[i]);
      drain_answers();

      // Random sets of one to five blocks.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         set_len = $urandom_range(1, 5);
         for (int i = 0; i < set_len; i++) begin
            push_block(pick_height(), i == set_len - 1);
            sent++;
         end
         if ($urandom_range(0, 7) == 0) drain_answers();
      end

      @(negedge clock) req_tvalid <= 1'b0;
      while (tracker.answers_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.answers_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
